// ----- rtl/core/event_slot_table_with_poll_scan_defines.svh -----
// assertion macros for the event slot table checker
`ifndef EVENT_SLOT_TABLE_WITH_POLL_SCAN_DEFINES_SVH
`define EVENT_SLOT_TABLE_WITH_POLL_SCAN_DEFINES_SVH

// same-cycle implication, disabled in reset
`define EST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("event slot table check failed");

// next-cycle implication, disabled in reset
`define EST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("event slot table check failed");

`endif

// ----- rtl/core/est_pkg.sv -----
// shared constants and types of the event slot table
`timescale 1ns / 1ps
package est_pkg;

  localparam int NUM_SLOTS_DEF   = 256;
  localparam int POLL_BUDGET_DEF = 8;

  // operation codes
  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_FREE  = 3'd1;
  localparam logic [2:0] OP_TOUCH = 3'd2;
  localparam logic [2:0] OP_FIRE  = 3'd3;
  localparam logic [2:0] OP_POLL  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ENABLE     = 2'd0;
  localparam logic [1:0] CFG_SLOT_COUNT = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

  // configuration reset values
  localparam logic        ENABLE_RST     = 1'b1;
  localparam logic [8:0]  SLOT_COUNT_RST = 9'd256;
  localparam logic [63:0] TIMEOUT_RST    = 64'd4000000000;

  // one slot entry as held in the slot memory, in-use bit included
  typedef struct packed {
    logic        in_use;
    logic [63:0] data;
    logic [63:0] stamp;
    logic        armed;
    logic        fired;
  } slot_entry_t;

endpackage

// ----- rtl/core/est_slot_ram.sv -----
// slot entry memory, one read and one write port, entries read as zero until written
`timescale 1ns / 1ps
module est_slot_ram #(
  parameter int DEPTH = est_pkg::NUM_SLOTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output est_pkg::slot_entry_t rd_entry,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  est_pkg::slot_entry_t wr_entry
);

  est_pkg::slot_entry_t mem [DEPTH];
  est_pkg::slot_entry_t rd_q_r;
  logic [DEPTH-1:0]     vld_r;
  logic                 rd_vld_r;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // written marks, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_entry = rd_vld_r ? rd_q_r : '0;

endmodule

// ----- rtl/core/event_slot_table_with_poll_scan.sv -----
// top level of the event slot table with poll scan
`timescale 1ns / 1ps
// Event slot table. An operation is taken when start is high and busy is low;
// busy stays high while it is worked on and falls in the cycle that shows its
// last result, so the next operation can be taken at the edge that takes that
// result. Results appear on the out_ ports for one cycle each, marked by
// out_valid, and must be taken then. All per-slot state, the in-use bit too,
// sits in one memory with a registered read. An unknown operation or a
// bad slot id, and an allocate while disabled or with no slots, shows its
// result in the cycle after the accepting edge. Free, touch and fire read
// the slot and write it back in S_UWR, which registers the result. Allocate
// reads one entry per cycle from the next-fit pointer, passing occupied
// slots, until it takes a free slot or finds every live slot occupied. Poll
// visits slots in S_PSCAN then S_PEVAL, wrapping to slot 0 at most once,
// then emits its results one per cycle in S_PEMIT.
// Configuration writes are always ready and belong between operations.
module event_slot_table_with_poll_scan #(
  parameter int NUM_SLOTS   = est_pkg::NUM_SLOTS_DEF,
  parameter int POLL_BUDGET = est_pkg::POLL_BUDGET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [8:0]  in_slot_id,
  input  logic [63:0] in_user_data,
  input  logic [63:0] in_now_time,
  input  logic        in_flush,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [8:0]  out_granted_slot,
  output logic [63:0] out_event_data,
  output logic        out_expired,
  output logic        out_event_valid,
  output logic        out_last,
  output logic [8:0]  out_scanned_count,
  output logic [8:0]  out_in_use_count
);

  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int IW = $clog2(NUM_SLOTS);
  localparam int FW = $clog2(POLL_BUDGET + 1);
  localparam int BW = (POLL_BUDGET > 1) ? $clog2(POLL_BUDGET) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ASRCH = 4'd1;
  localparam logic [3:0] S_UWR   = 4'd3;
  localparam logic [3:0] S_PSCAN = 4'd4;
  localparam logic [3:0] S_PEVAL = 4'd5;
  localparam logic [3:0] S_PEMIT = 4'd6;

  logic [3:0]    state_r, state_nxt;
  logic          enable_r;
  logic [8:0]    slot_count_r;
  logic [63:0]   timeout_r;
  logic [2:0]    op_r, op_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [63:0]   data_r, data_nxt;
  logic [63:0]   now_r, now_nxt;
  logic          flush_r, flush_nxt;
  logic [CW-1:0] p_r, p_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] first_r, first_nxt;
  logic          wrapped_r, wrapped_nxt;
  logic [FW-1:0] found_r, found_nxt;
  logic [FW-1:0] loops_r, loops_nxt;
  logic [CW-1:0] idle_r, idle_nxt;
  logic [FW-1:0] e_r, e_nxt;
  logic [CW-1:0] alloc_ptr_r, alloc_ptr_nxt;
  logic [CW-1:0] scan_ptr_r, scan_ptr_nxt;
  logic [CW-1:0] total_r, total_nxt;

  logic          ov_r, ov_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [8:0]    oslot_r, oslot_nxt;
  logic [63:0]   odata_r, odata_nxt;
  logic          oexp_r, oexp_nxt;
  logic          oevv_r, oevv_nxt;
  logic          olast_r, olast_nxt;
  logic [8:0]    oscan_r, oscan_nxt;
  logic [8:0]    ouse_r, ouse_nxt;

  logic [CW-1:0] buf_slot_r [POLL_BUDGET];
  logic [63:0]   buf_data_r [POLL_BUDGET];
  logic          buf_exp_r  [POLL_BUDGET];
  logic          buf_we;
  logic [CW-1:0] buf_slot_w;
  logic [63:0]   buf_data_w;
  logic          buf_exp_w;

  logic [CW-1:0] live_n;
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  est_pkg::slot_entry_t rd_entry, wr_entry;
  logic          age_hit, ready_hit, hit;
  logic [CW:0]   scan_sum;

  // effective slot count
  assign live_n = (32'(slot_count_r) > NUM_SLOTS) ? CW'(NUM_SLOTS) : CW'(slot_count_r);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign scan_sum  = (CW + 1)'(found_r) + (CW + 1)'(idle_r);

  // poll readiness of the entry just read
  assign ready_hit = rd_entry.armed && (rd_entry.data != 64'd0);
  assign age_hit   = (now_r != 64'd0) && (rd_entry.stamp != 64'd0) &&
                     ((now_r - rd_entry.stamp) > timeout_r);
  assign hit       = ready_hit && (rd_entry.fired || flush_r || age_hit);

  est_slot_ram #(
    .DEPTH (NUM_SLOTS),
    .AW    (IW)
  ) u_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    data_nxt      = data_r;
    now_nxt       = now_r;
    flush_nxt     = flush_r;
    p_nxt         = p_r;
    cnt_nxt       = cnt_r;
    first_nxt     = first_r;
    wrapped_nxt   = wrapped_r;
    found_nxt     = found_r;
    loops_nxt     = loops_r;
    idle_nxt      = idle_r;
    e_nxt         = e_r;
    alloc_ptr_nxt = alloc_ptr_r;
    scan_ptr_nxt  = scan_ptr_r;
    total_nxt     = total_r;
    ov_nxt        = 1'b0;
    ost_nxt       = ost_r;
    oslot_nxt     = oslot_r;
    odata_nxt     = odata_r;
    oexp_nxt      = oexp_r;
    oevv_nxt      = oevv_r;
    olast_nxt     = olast_r;
    oscan_nxt     = oscan_r;
    ouse_nxt      = ouse_r;
    rd_en         = 1'b0;
    rd_addr       = p_r[IW-1:0];
    wr_en         = 1'b0;
    wr_addr       = p_r[IW-1:0];
    wr_entry      = rd_entry;
    buf_we        = 1'b0;
    buf_slot_w    = p_r + CW'(1);
    buf_data_w    = rd_entry.data;
    buf_exp_w     = !rd_entry.fired;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_operation;
          idx_nxt   = IW'(32'(in_slot_id) - 32'd1);
          data_nxt  = in_user_data;
          now_nxt   = in_now_time;
          flush_nxt = in_flush;
          // single-result defaults
          ost_nxt   = est_pkg::ST_INVALID;
          oslot_nxt = '0;
          odata_nxt = '0;
          oexp_nxt  = 1'b0;
          oevv_nxt  = 1'b0;
          olast_nxt = 1'b1;
          oscan_nxt = '0;
          ouse_nxt  = 9'(total_r);
          if (in_operation == est_pkg::OP_ALLOC) begin
            if (!enable_r || live_n == '0) begin
              ov_nxt  = 1'b1;
              ost_nxt = est_pkg::ST_FULL;
            end else begin
              p_nxt     = (alloc_ptr_r < live_n) ? alloc_ptr_r : '0;
              cnt_nxt   = '0;
              rd_en     = 1'b1;
              rd_addr   = p_nxt[IW-1:0];
              state_nxt = S_ASRCH;
            end
          end else if (in_operation == est_pkg::OP_POLL) begin
            first_nxt   = (scan_ptr_r < live_n) ? scan_ptr_r : live_n;
            p_nxt       = (scan_ptr_r < live_n) ? scan_ptr_r : live_n;
            wrapped_nxt = 1'b0;
            found_nxt   = '0;
            loops_nxt   = '0;
            idle_nxt    = '0;
            e_nxt       = '0;
            state_nxt   = S_PSCAN;
          end else if ((in_operation == est_pkg::OP_FREE ||
                        in_operation == est_pkg::OP_TOUCH ||
                        in_operation == est_pkg::OP_FIRE) &&
                       in_slot_id != 9'd0 && 32'(in_slot_id) <= 32'(live_n)) begin
            rd_en     = 1'b1;
            rd_addr   = IW'(32'(in_slot_id) - 32'd1);
            state_nxt = S_UWR;
          end else begin
            ov_nxt = 1'b1;
          end
        end
      end

      S_ASRCH: begin
        // next-fit walk, one entry looked at per cycle
        if (!rd_entry.in_use) begin
          wr_en           = 1'b1;
          wr_entry.in_use = 1'b1;
          wr_entry.data   = data_r;
          wr_entry.stamp  = '0;
          wr_entry.armed  = 1'b1;
          alloc_ptr_nxt   = p_r + CW'(1);
          total_nxt       = total_r + CW'(1);
          ov_nxt          = 1'b1;
          ost_nxt         = est_pkg::ST_OK;
          oslot_nxt       = 9'(p_r + CW'(1));
          ouse_nxt        = 9'(total_r + CW'(1));
          state_nxt       = S_IDLE;
        end else if (cnt_r + CW'(1) == live_n) begin
          ov_nxt    = 1'b1;
          ost_nxt   = est_pkg::ST_FULL;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
          p_nxt   = (p_r + CW'(1) == live_n) ? '0 : p_r + CW'(1);
          rd_en   = 1'b1;
          rd_addr = p_nxt[IW-1:0];
        end
      end

      S_UWR: begin
        // read-modify-write of the addressed slot
        wr_en   = 1'b1;
        wr_addr = idx_r;
        ov_nxt  = 1'b1;
        ost_nxt = rd_entry.in_use ? est_pkg::ST_OK : est_pkg::ST_INVALID;
        if (op_r == est_pkg::OP_FREE) begin
          wr_entry.in_use = 1'b0;
          wr_entry.armed  = 1'b0;
          wr_entry.fired  = 1'b0;
          if (rd_entry.in_use) begin
            total_nxt = total_r - CW'(1);
            ouse_nxt  = 9'(total_r - CW'(1));
          end
        end else if (op_r == est_pkg::OP_TOUCH) begin
          wr_entry.stamp = now_r;
        end else begin
          wr_entry.fired = 1'b1;
        end
        state_nxt = S_IDLE;
      end

      S_PSCAN: begin
        // range and wrap handling, then read of the current slot
        if (!wrapped_r && p_r >= live_n) begin
          if (first_r == '0) begin
            state_nxt = S_PEMIT;
          end else begin
            p_nxt       = '0;
            wrapped_nxt = 1'b1;
          end
        end else if (wrapped_r && p_r >= first_r) begin
          state_nxt = S_PEMIT;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_PEVAL;
        end
      end

      S_PEVAL: begin
        if (!rd_entry.in_use) begin
          p_nxt     = p_r + CW'(1);
          state_nxt = S_PSCAN;
        end else if (found_r != '0 && loops_r == FW'(POLL_BUDGET)) begin
          state_nxt = S_PEMIT;
        end else begin
          if (loops_r != FW'(POLL_BUDGET)) begin
            loops_nxt = loops_r + FW'(1);
          end
          if (hit) begin
            buf_we        = 1'b1;
            wr_en         = 1'b1;
            wr_entry.data = '0;
            found_nxt     = found_r + FW'(1);
            if (idle_r == '0) begin
              scan_ptr_nxt = p_r + CW'(1);
            end
          end else begin
            idle_nxt = idle_r + CW'(1);
            if (idle_r == '0) begin
              scan_ptr_nxt = p_r;
            end
          end
          p_nxt     = p_r + CW'(1);
          state_nxt = S_PSCAN;
        end
      end

      S_PEMIT: begin
        ov_nxt    = 1'b1;
        ost_nxt   = est_pkg::ST_OK;
        oscan_nxt = 9'(scan_sum);
        ouse_nxt  = 9'(total_r);
        if (found_r == '0) begin
          oslot_nxt = '0;
          odata_nxt = '0;
          oexp_nxt  = 1'b0;
          oevv_nxt  = 1'b0;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          oslot_nxt = 9'(buf_slot_r[e_r[BW-1:0]]);
          odata_nxt = buf_data_r[e_r[BW-1:0]];
          oexp_nxt  = buf_exp_r[e_r[BW-1:0]];
          oevv_nxt  = 1'b1;
          olast_nxt = (e_r + FW'(1) == found_r);
          e_nxt     = e_r + FW'(1);
          if (e_r + FW'(1) == found_r) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      alloc_ptr_r  <= '0;
      scan_ptr_r   <= '0;
      total_r      <= '0;
      ov_r         <= 1'b0;
      enable_r     <= est_pkg::ENABLE_RST;
      slot_count_r <= est_pkg::SLOT_COUNT_RST;
      timeout_r    <= est_pkg::TIMEOUT_RST;
    end else begin
      state_r     <= state_nxt;
      alloc_ptr_r <= alloc_ptr_nxt;
      scan_ptr_r  <= scan_ptr_nxt;
      total_r     <= total_nxt;
      ov_r        <= ov_nxt;
      // configuration transfer
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          est_pkg::CFG_ENABLE:     enable_r     <= cfg_data[0];
          est_pkg::CFG_SLOT_COUNT: slot_count_r <= cfg_data[8:0];
          est_pkg::CFG_TIMEOUT:    timeout_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    idx_r     <= idx_nxt;
    data_r    <= data_nxt;
    now_r     <= now_nxt;
    flush_r   <= flush_nxt;
    p_r       <= p_nxt;
    cnt_r     <= cnt_nxt;
    first_r   <= first_nxt;
    wrapped_r <= wrapped_nxt;
    found_r   <= found_nxt;
    loops_r   <= loops_nxt;
    idle_r    <= idle_nxt;
    e_r       <= e_nxt;
    ost_r     <= ost_nxt;
    oslot_r   <= oslot_nxt;
    odata_r   <= odata_nxt;
    oexp_r    <= oexp_nxt;
    oevv_r    <= oevv_nxt;
    olast_r   <= olast_nxt;
    oscan_r   <= oscan_nxt;
    ouse_r    <= ouse_nxt;
    if (buf_we) begin
      buf_slot_r[found_r[BW-1:0]] <= buf_slot_w;
      buf_data_r[found_r[BW-1:0]] <= buf_data_w;
      buf_exp_r[found_r[BW-1:0]]  <= buf_exp_w;
    end
  end

  assign out_valid         = ov_r;
  assign out_status        = ost_r;
  assign out_granted_slot  = oslot_r;
  assign out_event_data    = odata_r;
  assign out_expired       = oexp_r;
  assign out_event_valid   = oevv_r;
  assign out_last          = olast_r;
  assign out_scanned_count = oscan_r;
  assign out_in_use_count  = ouse_r;

endmodule

// ----- rtl/core/est_checker.sv -----
// port-level checks of the event slot table and their binding
`timescale 1ns / 1ps
`include "event_slot_table_with_poll_scan_defines.svh"
module est_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [8:0] out_granted_slot,
  input logic       out_event_valid,
  input logic       out_last
);

  // poll results come back to back until the last one
  `EST_ASSERT_NEXT(a_burst_contiguous, out_valid && !out_last, out_valid)
  // the block stays busy while more results of a poll are due
  `EST_ASSERT_NOW(a_busy_in_burst, out_valid && !out_last, busy)
  // a reported event always names a slot
  `EST_ASSERT_NOW(a_event_has_slot, out_valid && out_event_valid, out_granted_slot != 9'd0)
  // reported events only come with ok status
  `EST_ASSERT_NOW(a_event_ok, out_valid && out_event_valid, out_status == est_pkg::ST_OK)

endmodule

bind event_slot_table_with_poll_scan est_checker u_est_checker (.*);
